// File: hdl/clpp_pkg.sv
// package: shared types, character codes and command name table for the prefix parser
`default_nettype none
package clpp_pkg;

    localparam int unsigned LINE_LEN_DEF = 64;
    localparam int unsigned NAME_COUNT   = 6;
    localparam int unsigned NAME_MAX_LEN = 8;
    localparam int unsigned NAME_POS_W   = 3;
    localparam int unsigned ID_W         = 3;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LZ  = 8'h7A;
    localparam logic [7:0] CASE_GAP = CH_LA - CH_UA;

    // names padded with nul up to eight characters, index 5 first
    localparam logic [NAME_COUNT-1:0][63:0] NAME_ROM = {
        {"VERSION", 8'h00},
        {"HELP", 32'h0},
        {"STEP", 32'h0},
        {"RELOCATE"},
        {"TAKEOFF", 8'h00},
        {"PUTON", 24'h0}
    };

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MD_CHAR,
        MD_BS,
        MD_CR
    } t_mode;

    typedef enum logic {
        TS_IDLE,
        TS_EMIT
    } t_top_state;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_FETCH,
        SC_TEST,
        SC_DONE
    } t_scan_state;

    typedef struct packed {
        logic            done;
        logic            has_word;
        logic            unique_hit;
        logic [ID_W-1:0] id;
        logic [7:0]      arg;
    } t_scan_stat;

    function automatic logic [7:0] name_char(input logic [ID_W-1:0] k,
                                             input logic [NAME_POS_W-1:0] pos);
        logic [63:0] w;
        begin
            w = (k < ID_W'(NAME_COUNT)) ? NAME_ROM[k] : 64'h0;
            return w[{NAME_POS_W'(NAME_MAX_LEN - 1) - pos, 3'b000} +: 8];
        end
    endfunction

    function automatic logic [ID_W-1:0] first_set(input logic [NAME_COUNT-1:0] a);
        logic [ID_W-1:0] id;
        begin
            id = '0;
            for (int k = NAME_COUNT - 1; k >= 0; k--) begin
                if (a[k]) begin
                    id = ID_W'(k);
                end
            end
            return id;
        end
    endfunction

    function automatic logic is_single(input logic [NAME_COUNT-1:0] a);
        return (a != '0) && ((a & (a - 1'b1)) == '0);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c inside {[CH_LA:CH_LZ]}) ? (c - CASE_GAP) : c;
    endfunction

endpackage
`default_nettype wire

// File: hdl/clpp_ifs.sv
// interfaces: received byte channel and result channel
`default_nettype none
interface clpp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface clpp_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] command_id;
    logic [7:0] arg_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output command_id,
                    output arg_byte, output last, input ready);
    modport sink (input valid, input kind, input out_byte, input command_id,
                  input arg_byte, input last, output ready);
endinterface
`default_nettype wire

// File: hdl/clpp_line_mem.sv
// line store: one write port, one registered read port
`default_nettype none
module clpp_line_mem #(
    parameter int unsigned DEPTH  = clpp_pkg::LINE_LEN_DEF,
    parameter int unsigned ADDR_W = $clog2(clpp_pkg::LINE_LEN_DEF)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hdl/clpp_scan.sv
// line scanner: walks the stored line, splits word and argument, matches name prefixes
`default_nettype none
module clpp_scan #(
    parameter int unsigned LEN_W  = $clog2(clpp_pkg::LINE_LEN_DEF + 1),
    parameter int unsigned ADDR_W = $clog2(clpp_pkg::LINE_LEN_DEF)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [LEN_W-1:0]      i_len,
    output logic      [ADDR_W-1:0]     o_raddr,
    input  wire logic [7:0]            i_rdata,
    output clpp_pkg::t_scan_stat       o_stat
);

    clpp_pkg::t_scan_state                r_state, n_state;
    logic [LEN_W-1:0]                     r_idx, n_idx;
    logic [LEN_W-1:0]                     r_len, n_len;
    logic                                 r_in_arg, n_in_arg;
    logic                                 r_has_word, n_has_word;
    logic [clpp_pkg::NAME_COUNT-1:0]      r_alive, n_alive;
    logic [7:0]                           r_arg, n_arg;
    logic                                 in_range;

    assign o_raddr  = r_idx[ADDR_W-1:0];
    assign in_range = (r_idx[LEN_W-1:clpp_pkg::NAME_POS_W] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clpp_pkg::SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_len      <= n_len;
        r_in_arg   <= n_in_arg;
        r_has_word <= n_has_word;
        r_alive    <= n_alive;
        r_arg      <= n_arg;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_len      = r_len;
        n_in_arg   = r_in_arg;
        n_has_word = r_has_word;
        n_alive    = r_alive;
        n_arg      = r_arg;
        if (i_start) begin
            n_state    = clpp_pkg::SC_FETCH;
            n_idx      = '0;
            n_len      = i_len;
            n_in_arg   = 1'b0;
            n_has_word = 1'b0;
            n_alive    = '1;
            n_arg      = clpp_pkg::CH_NUL;
        end else begin
            case (r_state)
                clpp_pkg::SC_FETCH: begin
                    n_state = (r_idx == r_len) ? clpp_pkg::SC_DONE : clpp_pkg::SC_TEST;
                end
                clpp_pkg::SC_TEST: begin
                    if (!r_in_arg) begin
                        if (i_rdata == clpp_pkg::CH_NUL) begin
                            n_state = clpp_pkg::SC_DONE;
                        end else if (clpp_pkg::is_blank(i_rdata)) begin
                            n_in_arg = 1'b1;
                            n_idx    = r_idx + 1'b1;
                            n_state  = clpp_pkg::SC_FETCH;
                        end else begin
                            n_has_word = 1'b1;
                            for (int k = 0; k < clpp_pkg::NAME_COUNT; k++) begin
                                n_alive[k] = r_alive[k] & in_range &
                                    (clpp_pkg::name_char(clpp_pkg::ID_W'(k),
                                        r_idx[clpp_pkg::NAME_POS_W-1:0]) == i_rdata);
                            end
                            n_idx   = r_idx + 1'b1;
                            n_state = clpp_pkg::SC_FETCH;
                        end
                    end else if (clpp_pkg::is_blank(i_rdata)) begin
                        n_idx   = r_idx + 1'b1;
                        n_state = clpp_pkg::SC_FETCH;
                    end else begin
                        n_arg   = i_rdata;
                        n_state = clpp_pkg::SC_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.done       = (r_state == clpp_pkg::SC_DONE);
        o_stat.has_word   = r_has_word;
        o_stat.unique_hit = clpp_pkg::is_single(r_alive);
        o_stat.id         = clpp_pkg::first_set(r_alive);
        o_stat.arg        = r_arg;
    end

endmodule
`default_nettype wire

// File: hdl/command_line_prefix_parser.sv
// top level: line editor, result sequencer and output register of the prefix parser
//
//  channel | dir | payload                                   | handshake
//  i_rx    | in  | rx_byte                                   | valid/ready
//  o_res   | out | kind, out_byte, command_id, arg_byte, last | valid/ready
//
// a plain byte is echoed; a backspace echoes backspace, space, backspace; an empty carriage return
// echoes CR, LF; a carriage return on a stored line walks it through the single read port, a fetch
// and a test state per character, and follows LF with a command or error result if it holds a word
// synchronous reset clears the line length and control; the line store is not cleared
// a stalled result register holds the sequencer; the next byte waits until the last
// result of the previous one is in the output register
`default_nettype none
module command_line_prefix_parser #(
    parameter int unsigned LINE_LEN = clpp_pkg::LINE_LEN_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    clpp_rx_if.sink     i_rx,
    clpp_res_if.source  o_res
);

    localparam int unsigned LEN_W  = $clog2(LINE_LEN + 1);
    localparam int unsigned ADDR_W = $clog2(LINE_LEN);

    clpp_pkg::t_top_state       r_state, n_state;
    clpp_pkg::t_mode            r_mode, n_mode;
    logic [1:0]                 r_step, n_step;
    logic [LEN_W-1:0]           r_len, n_len;
    logic                       r_scan_on, n_scan_on;
    logic [7:0]                 r_char, n_char;
    logic                       r_out_valid, n_out_valid;
    clpp_pkg::t_kind            r_kind, n_kind;
    logic [7:0]                 r_obyte, n_obyte;
    logic [clpp_pkg::ID_W-1:0]  r_cid, n_cid;
    logic [7:0]                 r_arg, n_arg;
    logic                       r_last, n_last;

    logic                       mem_we;
    logic [7:0]                 mem_rdata;
    logic [ADDR_W-1:0]          scan_raddr;
    logic                       scan_start;
    clpp_pkg::t_scan_stat       w_scan;

    logic                       e_avail;
    logic                       e_final;
    clpp_pkg::t_kind            e_kind;
    logic [7:0]                 e_byte;
    logic [clpp_pkg::ID_W-1:0]  e_id;
    logic [7:0]                 e_arg;
    logic                       slot_free;

    clpp_line_mem #(
        .DEPTH  (LINE_LEN),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_len[ADDR_W-1:0]),
        .i_wdata (clpp_pkg::to_upper(i_rx.rx_byte)),
        .i_raddr (scan_raddr),
        .o_rdata (mem_rdata)
    );

    clpp_scan #(
        .LEN_W  (LEN_W),
        .ADDR_W (ADDR_W)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_len   (r_len),
        .o_raddr (scan_raddr),
        .i_rdata (mem_rdata),
        .o_stat  (w_scan)
    );

    assign i_rx.ready       = (r_state == clpp_pkg::TS_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_kind;
    assign o_res.out_byte   = r_obyte;
    assign o_res.command_id = r_cid;
    assign o_res.arg_byte   = r_arg;
    assign o_res.last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clpp_pkg::TS_IDLE;
            r_mode      <= clpp_pkg::MD_CHAR;
            r_step      <= '0;
            r_len       <= '0;
            r_scan_on   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_step      <= n_step;
            r_len       <= n_len;
            r_scan_on   <= n_scan_on;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_kind  <= n_kind;
        r_obyte <= n_obyte;
        r_cid   <= n_cid;
        r_arg   <= n_arg;
        r_last  <= n_last;
    end

    // result for the current sequencer step
    always_comb begin
        e_avail = 1'b0;
        e_final = 1'b0;
        e_kind  = clpp_pkg::KIND_ECHO;
        e_byte  = clpp_pkg::CH_NUL;
        e_id    = '0;
        e_arg   = clpp_pkg::CH_NUL;
        case (r_mode)
            clpp_pkg::MD_CHAR: begin
                e_avail = 1'b1;
                e_byte  = r_char;
                e_final = 1'b1;
            end
            clpp_pkg::MD_BS: begin
                e_avail = 1'b1;
                e_byte  = (r_step == 2'd1) ? clpp_pkg::CH_SP : clpp_pkg::CH_BS;
                e_final = (r_step == 2'd2);
            end
            clpp_pkg::MD_CR: begin
                case (r_step)
                    2'd0: begin
                        e_avail = 1'b1;
                        e_byte  = clpp_pkg::CH_CR;
                    end
                    2'd1: begin
                        e_avail = !r_scan_on || w_scan.done;
                        e_byte  = clpp_pkg::CH_LF;
                        e_final = !r_scan_on || !w_scan.has_word;
                    end
                    default: begin
                        e_avail = 1'b1;
                        e_final = 1'b1;
                        if (w_scan.unique_hit) begin
                            e_kind = clpp_pkg::KIND_CMD;
                            e_id   = w_scan.id;
                            e_arg  = w_scan.arg;
                        end else begin
                            e_kind = clpp_pkg::KIND_ERR;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_step      = r_step;
        n_len       = r_len;
        n_scan_on   = r_scan_on;
        n_char      = r_char;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_obyte     = r_obyte;
        n_cid       = r_cid;
        n_arg       = r_arg;
        n_last      = r_last;
        mem_we      = 1'b0;
        scan_start  = 1'b0;
        slot_free   = !r_out_valid || o_res.ready;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            clpp_pkg::TS_IDLE: begin
                if (i_rx.valid) begin
                    n_step = '0;
                    n_char = i_rx.rx_byte;
                    if (i_rx.rx_byte == clpp_pkg::CH_CR) begin
                        n_mode     = clpp_pkg::MD_CR;
                        n_state    = clpp_pkg::TS_EMIT;
                        n_scan_on  = (r_len != '0);
                        scan_start = (r_len != '0);
                        n_len      = '0;
                    end else if (i_rx.rx_byte == clpp_pkg::CH_BS) begin
                        if (r_len != '0) begin
                            n_mode  = clpp_pkg::MD_BS;
                            n_state = clpp_pkg::TS_EMIT;
                            n_len   = r_len - 1'b1;
                        end
                    end else if (clpp_pkg::is_blank(i_rx.rx_byte) && (r_len == '0)) begin
                        n_mode = r_mode;
                    end else if (r_len < LEN_W'(LINE_LEN)) begin
                        mem_we  = 1'b1;
                        n_mode  = clpp_pkg::MD_CHAR;
                        n_state = clpp_pkg::TS_EMIT;
                        n_len   = r_len + 1'b1;
                    end
                end
            end
            clpp_pkg::TS_EMIT: begin
                if (slot_free && e_avail) begin
                    n_out_valid = 1'b1;
                    n_kind      = e_kind;
                    n_obyte     = e_byte;
                    n_cid       = e_id;
                    n_arg       = e_arg;
                    n_last      = e_final;
                    n_step      = r_step + 1'b1;
                    if (e_final) begin
                        n_state = clpp_pkg::TS_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(LINE_LEN))
        else $error("line length beyond line size");

    a_cmd_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind != clpp_pkg::KIND_ECHO)) |-> o_res.last)
        else $error("command or error result not marked last");

    a_third_cr_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == clpp_pkg::TS_EMIT) && (r_mode == clpp_pkg::MD_CR) && (r_step == 2'd2))
        |-> (w_scan.done && w_scan.has_word))
        else $error("match result without a finished scan of a word");

    a_unique_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_scan.done && w_scan.unique_hit) |-> w_scan.has_word)
        else $error("unique match without a word");
`endif

endmodule
`default_nettype wire
